>>> sv/gmb_pkg.sv
// Shared types and constants of the mixture background pixel block.
// No dependencies.
`default_nettype none
package gmb_pkg;

   localparam int unsigned SCALE       = 100;
   localparam int unsigned STEP_DIVISOR = 30000;
   localparam int unsigned NORM_TOTAL  = 10000;
   localparam int unsigned MEAN_SPAN   = 25500;
   localparam int unsigned STEP_BASE   = 5;
   localparam int unsigned ROUND_HALF  = 50;
   localparam int unsigned SPREAD_MAX  = 32767;
   localparam int unsigned SPREAD_STEP = 10;
   localparam int unsigned COUNTDOWN_RESET = 20;

   // x/30000 = ((x>>4) * STEP_RECIP) >> STEP_SHIFT, exact for x < 2^30
   localparam int unsigned STEP_PRESHIFT = 4;
   localparam int unsigned STEP_RECIP    = 73300776;
   localparam int unsigned STEP_SHIFT    = 37;
   // x/100 = (x * SCALE_RECIP) >> SCALE_SHIFT, exact for x < 43690
   localparam int unsigned SCALE_RECIP   = 41944;
   localparam int unsigned SCALE_SHIFT   = 22;

   localparam int unsigned DIV_N_W = 32;
   localparam int unsigned DIV_D_W = 20;

   typedef enum logic [2:0] {
      REG_UPDATE_PERIOD   = 3'd0,
      REG_INITIAL_SPREAD  = 3'd1,
      REG_MATCH_THRESHOLD = 3'd2,
      REG_TIGHT_THRESHOLD = 3'd3,
      REG_MINIMUM_SPREAD  = 3'd4,
      REG_WEIGHT_FLOOR    = 3'd5,
      REG_WEIGHT_REWARD   = 3'd6,
      REG_WEIGHT_DECAY    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [5:0]  update_period;
      logic [14:0] initial_spread;
      logic [14:0] match_threshold;
      logic [14:0] tight_threshold;
      logic [14:0] minimum_spread;
      logic [13:0] weight_floor;
      logic [9:0]  weight_reward;
      logic [6:0]  weight_decay;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SCAN_START, ST_SCAN_WAIT, ST_SCAN_EVAL, ST_STEP_MUL, ST_STEP_START,
      ST_UPDATE, ST_DECAY, ST_FLOOR, ST_NORM_CHECK, ST_NMUL, ST_NSTART,
      ST_NWAIT, ST_NWRITE, ST_BUB_INIT, ST_BUBBLE, ST_BUB_END, ST_REP_INIT, ST_REPLACE,
      ST_BGV_START, ST_OUT
   } ctl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_SCAN_START, OP_SCAN_EVAL, OP_STEP_MUL, OP_STEP_START,
      OP_UPDATE, OP_DECAY, OP_FLOOR, OP_NMUL, OP_NSTART, OP_NWRITE, OP_BUB_INIT,
      OP_BUBBLE, OP_BUB_END, OP_REP_INIT, OP_REPLACE, OP_BGV_START, OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic match;
      logic last;
      logic pair_last;
      logic free;
      logic rep_last;
      logic norm_due;
      logic sum_zero;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

>>> sv/gmb_req_if.sv
// Request channel: one pixel sample.
// Depends on nothing.
`default_nettype none
interface gmb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface
`default_nettype wire

>>> sv/gmb_rsp_if.sv
// Response channel: background decision for one pixel sample.
// Depends on nothing.
`default_nettype none
interface gmb_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_background;
   logic       matched;
   logic [7:0] background_value;
   modport source (output valid, output is_background, output matched,
                   output background_value, input ready);
   modport sink (input valid, input is_background, input matched,
                 input background_value, output ready);
endinterface
`default_nettype wire

>>> sv/gmb_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Uses gmb_pkg for widths.
`default_nettype none
module gmb_divider
   import gmb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_N_W-1:0] dividend,
   input  wire logic [DIV_D_W-1:0] divisor,
   output logic [DIV_N_W-1:0]      quotient,
   output logic                    done
);
   localparam int unsigned CW = $clog2(DIV_N_W + 1);

   logic [DIV_N_W-1:0] quo_ff, quo_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [DIV_D_W:0]   shifted;
   logic [DIV_D_W:0]   trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_N_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CW'(DIV_N_W);
      end else if (cnt_ff != '0) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = trial[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

>>> sv/gmb_controller.sv
// Sequencer of the mixture update: scan, update, normalize, reorder, replace.
// Uses gmb_pkg for state, command and status types.
`default_nettype none
module gmb_controller
   import gmb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  dp_status_type      status,
   output logic               req_ready,
   output dp_cmd_type         cmd
);
   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_SCAN_START;
            end
         end
         ST_SCAN_START: begin
            cmd.op   = OP_SCAN_START;
            state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: begin
            if (status.div_done) state_in = ST_SCAN_EVAL;
         end
         ST_SCAN_EVAL: begin
            cmd.op = OP_SCAN_EVAL;
            if (status.match) state_in = ST_STEP_MUL;
            else if (status.last) state_in = ST_REP_INIT;
            else state_in = ST_SCAN_START;
         end
         ST_STEP_MUL: begin
            cmd.op   = OP_STEP_MUL;
            state_in = ST_STEP_START;
         end
         ST_STEP_START: begin
            cmd.op   = OP_STEP_START;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.op   = OP_UPDATE;
            state_in = ST_DECAY;
         end
         ST_DECAY: begin
            cmd.op   = OP_DECAY;
            state_in = status.norm_due ? ST_FLOOR : ST_BGV_START;
         end
         ST_FLOOR: begin
            cmd.op = OP_FLOOR;
            if (status.last) state_in = ST_NORM_CHECK;
         end
         ST_NORM_CHECK: begin
            state_in = status.sum_zero ? ST_BUB_INIT : ST_NMUL;
         end
         ST_NMUL: begin
            cmd.op   = OP_NMUL;
            state_in = ST_NSTART;
         end
         ST_NSTART: begin
            cmd.op   = OP_NSTART;
            state_in = ST_NWAIT;
         end
         ST_NWAIT: begin
            if (status.div_done) state_in = ST_NWRITE;
         end
         ST_NWRITE: begin
            cmd.op   = OP_NWRITE;
            state_in = status.last ? ST_BUB_INIT : ST_NMUL;
         end
         ST_BUB_INIT: begin
            cmd.op   = OP_BUB_INIT;
            state_in = ST_BUBBLE;
         end
         ST_BUBBLE: begin
            cmd.op = OP_BUBBLE;
            if (status.pair_last) state_in = ST_BUB_END;
         end
         ST_BUB_END: begin
            cmd.op   = OP_BUB_END;
            state_in = ST_BGV_START;
         end
         ST_REP_INIT: begin
            cmd.op   = OP_REP_INIT;
            state_in = ST_REPLACE;
         end
         ST_REPLACE: begin
            cmd.op = OP_REPLACE;
            if (status.free || status.rep_last) state_in = ST_BGV_START;
         end
         ST_BGV_START: begin
            cmd.op   = OP_BGV_START;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.op   = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

>>> sv/gmb_datapath.sv
// Mode storage, arithmetic and response register of the background model.
// Uses gmb_pkg and gmb_divider.
`default_nettype none
module gmb_datapath
   import gmb_pkg::*;
#(
   parameter int unsigned MODES = 10
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  dp_cmd_type      cmd,
   input  cfg_type         cfg,
   input  wire logic [7:0] req_pixel,
   input  wire logic       rsp_ready,
   output dp_status_type   status,
   output logic            rsp_valid,
   output logic            rsp_is_background,
   output logic            rsp_matched,
   output logic [7:0]      rsp_background_value
);
   localparam int unsigned IW  = $clog2(MODES);
   localparam int unsigned AVG = NORM_TOTAL / MODES;

   logic signed [15:0] mean_ff   [MODES];
   logic [14:0]        spread_ff [MODES];
   logic [15:0]        weight_ff [MODES];

   logic [14:0]   value_ff;
   logic [IW-1:0] ptr_ff, cnt_ff, rp_ff;
   logic          neg_ff;
   logic [14:0]   dist_ff;
   logic [29:0]   prod_ff;
   logic [15:0]   step_ff;
   logic [7:0]    bgv_ff;
   logic [19:0]   sum_ff;
   logic [5:0]    countdown_ff;
   logic signed [15:0] c_mean_ff;
   logic [14:0]   c_spread_ff;
   logic [15:0]   c_weight_ff;
   logic          bg_ff, hit_ff;
   logic          out_valid_ff, out_bg_ff, out_hit_ff;
   logic [7:0]    out_val_ff;

   logic               div_start;
   logic [DIV_N_W-1:0] div_n;
   logic [DIV_D_W-1:0] div_d;
   logic [DIV_N_W-1:0] quo;
   logic               div_done;

   gmb_divider u_div (
      .clock, .reset, .start(div_start), .dividend(div_n), .divisor(div_d),
      .quotient(quo), .done(div_done)
   );

   logic [IW-1:0]      rd_idx, ptr_next, rp_next;
   logic signed [15:0] rd_mean;
   logic [14:0]        rd_spread;
   logic [15:0]        rd_weight;
   logic signed [16:0] diff;
   logic signed [24:0] num;
   logic [23:0]        num_mag;
   logic [14:0]        dist_sat;
   logic               match;
   logic signed [17:0] step, mnew;
   logic signed [16:0] snew;
   logic [16:0]        wrew;
   logic [15:0]        wfloor;
   logic               swap;
   logic signed [16:0] bgv;
   logic [52:0]        step_prod;
   logic [31:0]        bgv_prod;
   logic [9:0]         bgv_quo;

   always_comb begin
      rd_idx    = (cmd.op == OP_BUBBLE) ? IW'(ptr_ff + 1'b1) : ptr_ff;
      rd_mean   = mean_ff[rd_idx];
      rd_spread = spread_ff[rd_idx];
      rd_weight = weight_ff[rd_idx];
      ptr_next  = (ptr_ff == IW'(MODES - 1)) ? '0 : IW'(ptr_ff + 1'b1);
      rp_next   = ptr_next;

      diff    = $signed({2'b00, value_ff}) - 17'(rd_mean);
      num     = 25'(diff) * 25'sd100;
      num_mag = num[24] ? 24'(-num) : num[23:0];

      dist_sat = (quo > DIV_N_W'(SPREAD_MAX)) ? 15'(SPREAD_MAX) : quo[14:0];
      match    = (dist_sat <= cfg.match_threshold);

      // spread*distance/30000 by reciprocal multiplication
      step_prod = 53'(prod_ff >> STEP_PRESHIFT) * 53'(STEP_RECIP);

      // mean moves toward the sample; zero quotient counts as upward
      step = $signed(18'(STEP_BASE) + 18'(step_ff));
      mnew = neg_ff ? 18'(rd_mean) - step : 18'(rd_mean) + step;
      if (mnew > 18'sd32767) mnew = 18'sd32767;
      if (mnew < -18'sd32768) mnew = -18'sd32768;

      if (dist_ff < cfg.tight_threshold) begin
         snew = $signed({2'b00, rd_spread}) - 17'(SPREAD_STEP);
         if (snew < $signed({2'b00, cfg.minimum_spread}))
            snew = $signed({2'b00, cfg.minimum_spread});
      end else begin
         snew = $signed({2'b00, rd_spread}) + 17'(SPREAD_STEP);
         if (snew > 17'(SPREAD_MAX)) snew = 17'(SPREAD_MAX);
      end

      wrew = 17'(rd_weight) + 17'(cfg.weight_reward);
      if (wrew[16]) wrew = 17'h0FFFF;

      wfloor = (rd_weight < 16'(cfg.weight_floor)) ? 16'(cfg.weight_floor) : rd_weight;
      swap   = (rd_weight > 16'(AVG)) && (c_weight_ff < rd_weight);

      // rounded mean of the first mode, divided by 100 via reciprocal
      bgv      = 17'(mean_ff[0]) + 17'(ROUND_HALF);
      bgv_prod = 32'(bgv[15:0]) * 32'(SCALE_RECIP);
      bgv_quo  = (bgv <= 0) ? '0 : 10'(bgv_prod >> SCALE_SHIFT);

      div_start = 1'b0;
      div_n     = '0;
      div_d     = 20'd1;
      case (cmd.op)
         OP_SCAN_START: begin
            div_start = 1'b1;
            div_n     = DIV_N_W'(num_mag);
            div_d     = (rd_spread == '0) ? 20'd1 : 20'(rd_spread);
         end
         OP_NSTART: begin
            div_start = 1'b1;
            div_n     = DIV_N_W'(prod_ff);
            div_d     = sum_ff;
         end
         default: ;
      endcase

      status.div_done  = div_done;
      status.match     = match;
      status.last      = (ptr_ff == IW'(MODES - 1));
      status.pair_last = (ptr_ff == IW'(MODES - 2));
      status.free      = (rd_weight <= 16'(AVG));
      status.rep_last  = (cnt_ff == IW'(MODES - 1));
      status.norm_due  = (countdown_ff <= 6'd1);
      status.sum_zero  = (sum_ff == '0);
      status.out_free  = !out_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MODES; i++) begin
            mean_ff[i]   <= 16'(MEAN_SPAN * i / MODES);
            spread_ff[i] <= 15'd1000;
            weight_ff[i] <= 16'(AVG);
         end
         countdown_ff <= 6'(COUNTDOWN_RESET);
         rp_ff        <= '0;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         bg_ff        <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         if (cmd.op == OP_OUT) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_LOAD: begin
               value_ff <= 15'(req_pixel * 15'd100);
               ptr_ff   <= '0;
               bg_ff    <= 1'b0;
               hit_ff   <= 1'b0;
            end
            OP_SCAN_START: neg_ff <= num[24];
            OP_SCAN_EVAL: begin
               dist_ff <= dist_sat;
               neg_ff  <= neg_ff && (quo != '0);
               if (!match) ptr_ff <= ptr_next;
            end
            OP_STEP_MUL: prod_ff <= 30'(rd_spread * dist_ff);
            OP_STEP_START: step_ff <= 16'(step_prod >> STEP_SHIFT);
            OP_UPDATE: begin
               mean_ff[ptr_ff]   <= mnew[15:0];
               spread_ff[ptr_ff] <= snew[14:0];
               weight_ff[ptr_ff] <= wrew[15:0];
               bg_ff             <= (rd_weight >= 16'(AVG));
               hit_ff            <= 1'b1;
            end
            OP_DECAY: begin
               for (int k = 0; k < MODES; k++) begin
                  weight_ff[k] <= (weight_ff[k] > 16'(cfg.weight_decay)) ?
                                  weight_ff[k] - 16'(cfg.weight_decay) : '0;
               end
               countdown_ff <= (countdown_ff <= 6'd1) ? cfg.update_period
                                                       : countdown_ff - 1'b1;
               ptr_ff <= '0;
               sum_ff <= '0;
            end
            OP_FLOOR: begin
               weight_ff[ptr_ff] <= wfloor;
               sum_ff            <= sum_ff + 20'(wfloor);
               ptr_ff            <= ptr_next;
            end
            OP_NMUL: prod_ff <= 30'(rd_weight * 14'd10000);
            OP_NWRITE: begin
               weight_ff[ptr_ff] <= quo[15:0];
               ptr_ff            <= ptr_next;
            end
            OP_BUB_INIT: begin
               c_mean_ff   <= mean_ff[0];
               c_spread_ff <= spread_ff[0];
               c_weight_ff <= weight_ff[0];
               ptr_ff      <= '0;
            end
            OP_BUBBLE: begin
               // the carried entry keeps sinking while the next one outranks it
               if (swap) begin
                  mean_ff[ptr_ff]   <= rd_mean;
                  spread_ff[ptr_ff] <= rd_spread;
                  weight_ff[ptr_ff] <= rd_weight;
               end else begin
                  mean_ff[ptr_ff]   <= c_mean_ff;
                  spread_ff[ptr_ff] <= c_spread_ff;
                  weight_ff[ptr_ff] <= c_weight_ff;
                  c_mean_ff         <= rd_mean;
                  c_spread_ff       <= rd_spread;
                  c_weight_ff       <= rd_weight;
               end
               ptr_ff <= ptr_next;
            end
            OP_BUB_END: begin
               mean_ff[ptr_ff]   <= c_mean_ff;
               spread_ff[ptr_ff] <= c_spread_ff;
               weight_ff[ptr_ff] <= c_weight_ff;
            end
            OP_REP_INIT: begin
               ptr_ff <= rp_ff;
               cnt_ff <= '0;
            end
            OP_REPLACE: begin
               if (rd_weight <= 16'(AVG)) begin
                  mean_ff[ptr_ff]   <= $signed({1'b0, value_ff});
                  spread_ff[ptr_ff] <= cfg.initial_spread;
                  rp_ff             <= rp_next;
               end else begin
                  ptr_ff <= ptr_next;
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            OP_BGV_START: bgv_ff <= (bgv_quo > 10'd255) ? 8'd255 : bgv_quo[7:0];
            OP_OUT: begin
               out_bg_ff  <= bg_ff;
               out_hit_ff <= hit_ff;
               out_val_ff <= bgv_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_is_background    = out_bg_ff;
   assign rsp_matched          = out_hit_ff;
   assign rsp_background_value = out_val_ff;
endmodule
`default_nettype wire

>>> sv/gaussian_mixture_background_pixel.sv
// Each request scans the modes in order (one serial division each), then either
// updates the matched mode (with a normalize and reorder pass when due) or
// replaces a light mode; the background value and the response register
// follow.
// Requests are taken one at a time; the shared serial divider sets the rate.
// Reset (synchronous, active high) loads register defaults and the initial modes.
`default_nettype none
module gaussian_mixture_background_pixel
   import gmb_pkg::*;
#(
   parameter int unsigned MODES = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   gmb_req_if.sink          req_bus,
   gmb_rsp_if.source        rsp_bus,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   // config registers, 4-byte stride
   cfg_type       cfg_ff;
   reg_index_type widx;
   reg_index_type ridx;

   assign pready = 1'b1;
   assign widx   = reg_index_type'(paddr[4:2]);
   assign ridx   = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.update_period   <= 6'd20;
         cfg_ff.initial_spread  <= 15'd1000;
         cfg_ff.match_threshold <= 15'd258;
         cfg_ff.tight_threshold <= 15'd60;
         cfg_ff.minimum_spread  <= 15'd200;
         cfg_ff.weight_floor    <= 14'd120;
         cfg_ff.weight_reward   <= 10'd20;
         cfg_ff.weight_decay    <= 7'd2;
      end else if (psel && penable && pwrite) begin
         case (widx)
            REG_UPDATE_PERIOD:   cfg_ff.update_period   <= pwdata[5:0];
            REG_INITIAL_SPREAD:  cfg_ff.initial_spread  <= pwdata[14:0];
            REG_MATCH_THRESHOLD: cfg_ff.match_threshold <= pwdata[14:0];
            REG_TIGHT_THRESHOLD: cfg_ff.tight_threshold <= pwdata[14:0];
            REG_MINIMUM_SPREAD:  cfg_ff.minimum_spread  <= pwdata[14:0];
            REG_WEIGHT_FLOOR:    cfg_ff.weight_floor    <= pwdata[13:0];
            REG_WEIGHT_REWARD:   cfg_ff.weight_reward   <= pwdata[9:0];
            REG_WEIGHT_DECAY:    cfg_ff.weight_decay    <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         REG_UPDATE_PERIOD:   prdata = 32'(cfg_ff.update_period);
         REG_INITIAL_SPREAD:  prdata = 32'(cfg_ff.initial_spread);
         REG_MATCH_THRESHOLD: prdata = 32'(cfg_ff.match_threshold);
         REG_TIGHT_THRESHOLD: prdata = 32'(cfg_ff.tight_threshold);
         REG_MINIMUM_SPREAD:  prdata = 32'(cfg_ff.minimum_spread);
         REG_WEIGHT_FLOOR:    prdata = 32'(cfg_ff.weight_floor);
         REG_WEIGHT_REWARD:   prdata = 32'(cfg_ff.weight_reward);
         REG_WEIGHT_DECAY:    prdata = 32'(cfg_ff.weight_decay);
         default:             prdata = '0;
      endcase
   end

   // controller drives one datapath command per cycle, OP_NONE while it waits on the divider or the output
   dp_cmd_type    cmd;
   dp_status_type status;

   gmb_controller u_ctl (
      .clock, .reset, .req_valid(req_bus.valid), .status,
      .req_ready(req_bus.ready), .cmd
   );

   // response register lets the next request start while a result waits
   gmb_datapath #(.MODES(MODES)) u_dp (
      .clock, .reset, .cmd, .cfg(cfg_ff), .req_pixel(req_bus.pixel),
      .rsp_ready(rsp_bus.ready), .status,
      .rsp_valid(rsp_bus.valid), .rsp_is_background(rsp_bus.is_background),
      .rsp_matched(rsp_bus.matched), .rsp_background_value(rsp_bus.background_value)
   );
endmodule
`default_nettype wire

>>> tb/gaussian_mixture_background_pixel_tb.sv
// Self-checking testbench for the mixture background pixel block.
// Depends on gmb_pkg, gmb_req_if, gmb_rsp_if and the block's RTL.
`default_nettype none
module gaussian_mixture_background_pixel_tb;
   import gmb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MODES = 10;
   localparam int AVG_W = NORM_TOTAL / MODES;
   localparam int STALL_LIMIT = 200000;

   typedef struct packed {
      logic       is_background;
      logic       matched;
      logic [7:0] background_value;
   } bg_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   gmb_req_if req_bus ();
   gmb_rsp_if rsp_bus ();

   gaussian_mixture_background_pixel #(.MODES(MODES)) dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Predictor state: shadow copy of the pixel's mixture and registers.
   cfg_type cfg;
   int mean_q[MODES];
   int spread_q[MODES];
   longint unsigned weight_q[MODES];
   int countdown_q;
   int rr_pos;

   logic [7:0] pixel_queue[$];
   bg_result_t expected_results[$];
   int fail_count = 0;
   int idle_cycles = 0;
   bit driver_enable = 1'b0;
   bit rsp_idle_on = 1'b1;     // random stalls of the receiver
   bit req_idle_on = 1'b1;
   int hold_off = 0;           // long receiver hold-off, counted down below

   task automatic model_reset();
      cfg.update_period = 20; cfg.initial_spread = 1000; cfg.match_threshold = 258;
      cfg.tight_threshold = 60; cfg.minimum_spread = 200; cfg.weight_floor = 120;
      cfg.weight_reward = 20; cfg.weight_decay = 2;
      for (int i = 0; i < MODES; i++) begin
         mean_q[i] = MEAN_SPAN * i / MODES;
         spread_q[i] = 1000;
         weight_q[i] = AVG_W;
      end
      countdown_q = COUNTDOWN_RESET;
      rr_pos = 0;
   endtask

   function automatic void normalize_and_sort();
      longint unsigned total;
      longint unsigned tw;
      int tm, ts;
      total = 0;
      for (int i = 0; i < MODES; i++) begin
         if (weight_q[i] < cfg.weight_floor) weight_q[i] = cfg.weight_floor;
         total += weight_q[i];
      end
      if (total != 0)
         for (int i = 0; i < MODES; i++) weight_q[i] = weight_q[i] * NORM_TOTAL / total;
      // one bubble pass, heavy modes move toward the front
      for (int i = 0; i < MODES - 1; i++) begin
         if (weight_q[i+1] > AVG_W && weight_q[i] < weight_q[i+1]) begin
            tw = weight_q[i]; tm = mean_q[i]; ts = spread_q[i];
            weight_q[i] = weight_q[i+1]; mean_q[i] = mean_q[i+1]; spread_q[i] = spread_q[i+1];
            weight_q[i+1] = tw; mean_q[i+1] = tm; spread_q[i+1] = ts;
         end
      end
   endfunction

   function automatic bg_result_t classify_pixel(logic [7:0] pix);
      bg_result_t r;
      int sample, dv, q, dist_mag, stp, m, s, idx, v, rv;
      bit hit, bg;
      sample = int'(pix) * SCALE;
      hit = 0; bg = 0;
      for (int i = 0; i < MODES && !hit; i++) begin
         dv = spread_q[i] > 0 ? spread_q[i] : 1;
         q = ((sample - mean_q[i]) * 100) / dv;   // truncates toward zero
         dist_mag = q >= 0 ? q : -q;
         if (dist_mag > 32767) dist_mag = 32767;
         if (dist_mag <= int'(cfg.match_threshold)) begin
            stp = STEP_BASE + int'((longint'(spread_q[i]) * dist_mag) / STEP_DIVISOR);
            m = q >= 0 ? mean_q[i] + stp : mean_q[i] - stp;
            if (m > 32767) m = 32767;
            if (m < -32768) m = -32768;
            mean_q[i] = m;
            s = spread_q[i];
            if (dist_mag < int'(cfg.tight_threshold)) begin
               s -= SPREAD_STEP;
               if (s < int'(cfg.minimum_spread)) s = cfg.minimum_spread;
            end else begin
               s += SPREAD_STEP;
               if (s > SPREAD_MAX) s = SPREAD_MAX;
            end
            spread_q[i] = s;
            bg = weight_q[i] >= AVG_W;
            hit = 1;
            weight_q[i] += cfg.weight_reward;
            if (weight_q[i] > 65535) weight_q[i] = 65535;
            for (int k = 0; k < MODES; k++)
               weight_q[k] = weight_q[k] > cfg.weight_decay ? weight_q[k] - cfg.weight_decay : 0;
            if (countdown_q <= 1) begin
               normalize_and_sort();
               countdown_q = cfg.update_period;
            end else begin
               countdown_q--;
            end
         end
      end
      if (!hit) begin
         // round-robin replacement of the next light mode
         for (int k = 0; k < MODES; k++) begin
            idx = (rr_pos + k) % MODES;
            if (weight_q[idx] <= AVG_W) begin
               rr_pos = (idx + 1) % MODES;
               mean_q[idx] = sample;
               spread_q[idx] = cfg.initial_spread;
               break;
            end
         end
      end
      v = mean_q[0] + ROUND_HALF;
      rv = v <= 0 ? 0 : v / 100;
      if (rv > 255) rv = 255;
      r.is_background = bg;
      r.matched = hit;
      r.background_value = rv[7:0];
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // APB write: setup then access cycle; shadow updated alongside.
   task automatic csr_write(reg_index_type idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= 5'(4 * int'(idx)); pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_UPDATE_PERIOD:   cfg.update_period = val[5:0];
         REG_INITIAL_SPREAD:  cfg.initial_spread = val[14:0];
         REG_MATCH_THRESHOLD: cfg.match_threshold = val[14:0];
         REG_TIGHT_THRESHOLD: cfg.tight_threshold = val[14:0];
         REG_MINIMUM_SPREAD:  cfg.minimum_spread = val[14:0];
         REG_WEIGHT_FLOOR:    cfg.weight_floor = val[13:0];
         REG_WEIGHT_REWARD:   cfg.weight_reward = val[9:0];
         default:             cfg.weight_decay = val[6:0];
      endcase
   endtask

   task automatic write_all(int up, int isp, int mt, int tt, int ms, int wf, int wr, int wd);
      csr_write(REG_UPDATE_PERIOD, up);
      csr_write(REG_INITIAL_SPREAD, isp);
      csr_write(REG_MATCH_THRESHOLD, mt);
      csr_write(REG_TIGHT_THRESHOLD, tt);
      csr_write(REG_MINIMUM_SPREAD, ms);
      csr_write(REG_WEIGHT_FLOOR, wf);
      csr_write(REG_WEIGHT_REWARD, wr);
      csr_write(REG_WEIGHT_DECAY, wd);
   endtask

   // Wait until the block has drained every request, then a margin.
   task automatic drain();
      wait (pixel_queue.size() == 0 && !req_bus.valid && expected_results.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   // Random pixels cluster around a few levels so modes match and settle.
   task automatic queue_random(int n);
      int centers[3];
      int p;
      for (int c = 0; c < 3; c++) centers[c] = $urandom_range(255);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 80) begin
            p = centers[$urandom_range(2)] + $urandom_range(6) - 3;
            if (p < 0) p = 0;
            if (p > 255) p = 255;
         end else begin
            p = $urandom_range(255);
         end
         pixel_queue.push_back(p[7:0]);
      end
   endtask

   // Driver: presents queued pixels, idles at random.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.pixel <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(classify_pixel(req_bus.pixel));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (driver_enable && pixel_queue.size() != 0 &&
                (!req_idle_on || $urandom_range(99) >= 23)) begin
               req_bus.valid <= 1'b1;
               req_bus.pixel <= pixel_queue.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: response stalls, long hold-off, field checks and watchdog.
   always @(posedge clock) begin
      bg_result_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report("unexpected response", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.is_background !== want.is_background)
                  report("is_background", rsp_bus.is_background, want.is_background);
               if (rsp_bus.matched !== want.matched)
                  report("matched", rsp_bus.matched, want.matched);
               if (rsp_bus.background_value !== want.background_value)
                  report("background_value", rsp_bus.background_value,
                         want.background_value);
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !rsp_idle_on || $urandom_range(99) >= 23;
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("timeout waiting for the block");
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      model_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      driver_enable = 1'b1;

      // Directed: field extremes, exact hits on the reset means, distant values.
      pixel_queue.push_back(8'd0);
      pixel_queue.push_back(8'd255);
      pixel_queue.push_back(8'd0);
      pixel_queue.push_back(8'd128);
      pixel_queue.push_back(8'd51);   // sits exactly on a reset mean; the scan still matches the mode before it
      pixel_queue.push_back(8'd51);
      pixel_queue.push_back(8'd170);
      pixel_queue.push_back(8'd85);
      pixel_queue.push_back(8'd255);
      for (int i = 0; i < 12; i++) pixel_queue.push_back(8'd100);  // forces normalize pass
      drain();

      // Extremes: a zero match threshold lets only a zero quotient match; unmatched pixels replace light modes.
      write_all(1, 1, 0, 0, 1, 0, 0, 0);
      for (int i = 0; i < 6; i++) pixel_queue.push_back(i[0] ? 8'hFF : 8'h00);
      drain();
      // Huge spreads and thresholds, heavy weighting.
      write_all(63, 32767, 32767, 32767, 32767, 10000, 1000, 100);
      queue_random(40);
      drain();
      write_all(2, 32767, 32767, 0, 1, 0, 1000, 0);   // spread grows to saturation
      queue_random(30);
      drain();

      // Receiver hold-off while the sender keeps offering.
      write_all(20, 1000, 258, 60, 200, 120, 20, 2);
      queue_random(20);
      hold_off = 600;
      drain();

      // Random settings, each followed by random clustered pixels.
      for (int ph = 0; ph < 5; ph++) begin
         write_all($urandom_range(1, 63), $urandom_range(1, 4000), $urandom_range(0, 600),
                   $urandom_range(0, 200), $urandom_range(1, 500), $urandom_range(0, 2000),
                   $urandom_range(0, 1000), $urandom_range(0, 100));
         if (ph == 2) begin
            rsp_idle_on = 1'b0;     // long stretch with no idling at all
            req_idle_on = 1'b0;
         end else begin
            rsp_idle_on = 1'b1;
            req_idle_on = 1'b1;
         end
         queue_random(60);
         drain();
      end

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
